@@ sv/joystick_axis_calibrate_scale_top_assert.svh @@
// Assertion macros for the joystick axis calibrate and scale block.
`ifndef JOYSTICK_AXIS_CALIBRATE_SCALE_TOP_ASSERT_SVH
`define JOYSTICK_AXIS_CALIBRATE_SCALE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define JACS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define JACS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define JACS_ASSERT_SAME(label, clk, rst, ante, cons)
`define JACS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/jacs_pkg.sv @@
package jacs_pkg;

  // default converter width
  localparam int SAMPLE_BITS_DEF = 10;
  // full-scale tilt and its quotient width
  localparam int TILT_FULL  = 127;
  localparam int QUOT_BITS  = 7;
  localparam int CNT_BITS   = $clog2(QUOT_BITS);
  localparam int TILT_BITS  = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic finish;
  } cmd_t;

endpackage

@@ sv/jacs_ctrl.sv @@
module jacs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_ready,
  output logic            in_ready,
  output logic            out_valid,
  output jacs_pkg::cmd_t  cmd
);
  import jacs_pkg::*;

  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(QUOT_BITS - 1);

  state_t              state, state_next;
  logic [CNT_BITS-1:0] cnt;
  logic                out_full;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_PREP;
      ST_PREP: state_next = ST_DIV;
      ST_DIV:  if (cnt == LAST_STEP) state_next = ST_DONE;
      ST_DONE: if (!out_full || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_PREP: cmd.prep = 1'b1;
      ST_DIV:  cmd.step = 1'b1;
      ST_DONE: cmd.finish = !out_full || out_ready;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // divide step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.prep) begin
      cnt <= '0;
    end else if (cmd.step) begin
      cnt <= cnt + 1'b1;
    end
  end

  // output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.finish) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  assign out_valid = out_full;

endmodule

@@ sv/jacs_dp.sv @@
module jacs_dp #(
  parameter int SAMPLE_BITS = jacs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  jacs_pkg::cmd_t                       cmd,
  input  logic [SAMPLE_BITS-1:0]               sample,
  input  logic                                 calibrate,
  output logic signed [jacs_pkg::TILT_BITS-1:0] tilt,
  output logic [SAMPLE_BITS-1:0]               lowest_seen,
  output logic [SAMPLE_BITS-1:0]               highest_seen,
  output logic [SAMPLE_BITS-1:0]               centre_now
);
  import jacs_pkg::*;

  localparam int NW = SAMPLE_BITS + QUOT_BITS;

  logic [SAMPLE_BITS-1:0] run_min, run_max, centre, s_reg;
  logic [SAMPLE_BITS-1:0] num, den;
  logic                   above, below;
  logic [NW-1:0]          rem, dsh;
  logic [QUOT_BITS-1:0]   quot;
  logic                   neg, zero;
  logic [TILT_BITS-1:0]   mag;

  // running extremes and centre, updated as the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      run_min <= '1;
      run_max <= '0;
      centre  <= '1;
    end else if (cmd.load) begin
      if (sample > run_max) run_max <= sample;
      if (sample < run_min) run_min <= sample;
      if (calibrate) centre <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) s_reg <= sample;
  end

  // deflection and span on the side of centre the sample falls
  always_comb begin
    above = s_reg > centre;
    below = s_reg < centre;
    if (above) begin
      num = s_reg - centre;
      den = run_max - centre;
    end else begin
      num = centre - s_reg;
      den = centre - run_min;
    end
  end

  // restoring divider: 127*num / den, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rem  <= {num, {QUOT_BITS{1'b0}}} - NW'(num);
      dsh  <= NW'(den) << (QUOT_BITS - 1);
      quot <= '0;
      neg  <= below;
      zero <= (!above && !below) || (den == '0);
    end else if (cmd.step) begin
      if (rem >= dsh) begin
        rem  <= rem - dsh;
        quot <= {quot[QUOT_BITS-2:0], 1'b1};
      end else begin
        quot <= {quot[QUOT_BITS-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  // quotient is at most 127 by construction of the 7-bit divider
  assign mag = zero ? '0 : TILT_BITS'(quot);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      tilt         <= neg ? -$signed(mag) : $signed(mag);
      lowest_seen  <= run_min;
      highest_seen <= run_max;
      centre_now   <= centre;
    end
  end

endmodule

@@ sv/joystick_axis_calibrate_scale_top.sv @@
// Joystick axis calibration and scaling.
// Input channel (in_valid/in_ready): one beat carries a converter sample and
// a calibrate flag. The block tracks the running minimum and maximum of all
// samples; a beat with calibrate set also becomes the new centre.
// Output channel (out_valid/out_ready): one beat per input beat, carrying the
// signed tilt (-127..127, scaled against the span on that side of centre)
// and the minimum, maximum and centre after that sample.
// Sequence from input accept to out_valid: extremes and centre update at the
// accept edge, then a set-up state, seven restoring divide steps and a result
// write. The shared divider produces one quotient bit per cycle and handles
// one beat at a time, so a new beat is taken only once the previous one has
// finished and the controller is back in idle.
// Reset (rst, synchronous): minimum and centre go to all ones, maximum to 0,
// output register empties.
// Stall: a finished result sits in the output register while out_ready is
// low; the next beat is accepted and computed meanwhile, and waits in the
// divider until the output register frees.
module joystick_axis_calibrate_scale_top #(
  parameter int SAMPLE_BITS = jacs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [SAMPLE_BITS-1:0]               sample,
  input  logic                                 calibrate,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [jacs_pkg::TILT_BITS-1:0] tilt,
  output logic [SAMPLE_BITS-1:0]               lowest_seen,
  output logic [SAMPLE_BITS-1:0]               highest_seen,
  output logic [SAMPLE_BITS-1:0]               centre_now
);
  import jacs_pkg::*;

  cmd_t cmd;

  jacs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  jacs_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sample       (sample),
    .calibrate    (calibrate),
    .tilt         (tilt),
    .lowest_seen  (lowest_seen),
    .highest_seen (highest_seen),
    .centre_now   (centre_now)
  );

`include "joystick_axis_calibrate_scale_top_assert.svh"

  // extremes are ordered once any sample has been seen
  `JACS_ASSERT_SAME(a_min_le_max, clk, rst, out_valid, lowest_seen <= highest_seen)
  // tilt never reaches the most negative code
  `JACS_ASSERT_SAME(a_tilt_range, clk, rst, out_valid, tilt != 8'sh80)
  // one beat in flight: no accept in the cycle after an accept
  `JACS_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

endmodule
